// ----- hdl/ste_pkg.sv -----
// Package for the smoothed target encoder: sizes, field widths and the
// command and status structs between controller and datapath. No dependencies.
`default_nettype none
package ste_pkg;

  localparam int NUM_CAT  = 256;
  localparam int IDX_W    = $clog2(NUM_CAT);
  localparam int CODE_W   = 9;
  localparam int MAX_ROWS = 1048576;
  localparam int ROWS_W   = 21;
  localparam int SUM_W    = 52;
  localparam int VAL_W    = 32;
  localparam int SMOOTH_W = 16;
  localparam int PROD_W   = SMOOTH_W + 1 + VAL_W;
  localparam int DIVN_W   = 64;
  localparam int DIVD_W   = 32;

  // commands from controller to datapath
  typedef struct packed {
    logic take;        // input beat accepted, latch it and read tables
    logic acc_wr;      // write back accumulate row
    logic enc_take;    // encode result handed to output register
    logic mean_start;  // start divider on totals
    logic mean_zero;   // no rows: global mean is zero
    logic mean_load;   // store divider result as global mean
    logic prod;        // form smoothing * mean, rewind walk counter
    logic num_load;    // register numerator and denominator
    logic div_start;   // start divider on category quotient
    logic val_wr_mean; // category empty: value gets global mean
    logic val_wr_div;  // category value from divider
  } ste_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic cmd_enc;
    logic last;
    logic rows_zero;
    logic walk_skip;
    logic walk_end;
    logic div_done;
  } ste_stat_t;

endpackage
`default_nettype wire

// ----- hdl/ste_intf.sv -----
// Channel interfaces of the smoothed target encoder: row input, result
// output and configuration write. No dependencies.
`default_nettype none
interface ste_row_if;
  logic               valid;
  logic               ready;
  logic               command;
  logic signed [8:0]  category_code;
  logic signed [31:0] target_value;
  logic               last_row;
  modport source(output valid, command, category_code, target_value, last_row, input ready);
  modport sink(input valid, command, category_code, target_value, last_row, output ready);
endinterface

interface ste_res_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] encoded_value;
  logic               last_out;
  modport source(output valid, encoded_value, last_out, input ready);
  modport sink(input valid, encoded_value, last_out, output ready);
endinterface

interface ste_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface
`default_nettype wire

// ----- hdl/ste_div.sv -----
// Restoring divider, one quotient bit a cycle, unsigned.
// Uses ste_pkg for widths.
`default_nettype none
module ste_div (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [ste_pkg::DIVN_W-1:0] dividend,
  input  wire logic [ste_pkg::DIVD_W-1:0] divisor,
  output logic                            done,
  output logic [ste_pkg::DIVN_W-1:0]      quotient
);
  import ste_pkg::*;

  localparam int CNT_W = $clog2(DIVN_W);

  logic              busy;
  logic [CNT_W-1:0]  count;
  logic [DIVD_W-1:0] rem;
  logic [DIVD_W-1:0] dsr;
  logic [DIVD_W:0]   rem_sh;
  logic [DIVD_W:0]   diff;

  assign rem_sh = {rem, quotient[DIVN_W-1]};
  assign diff   = rem_sh - {1'b0, dsr};

  // control: run one step per dividend bit
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 1'b1;
        if (count == CNT_W'(DIVN_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath: shift, trial subtract, keep on no borrow
  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dsr      <= divisor;
    end else if (busy) begin
      if (!diff[DIVD_W]) begin
        rem      <= diff[DIVD_W-1:0];
        quotient <= {quotient[DIVN_W-2:0], 1'b1};
      end else begin
        rem      <= rem_sh[DIVD_W-1:0];
        quotient <= {quotient[DIVN_W-2:0], 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

// ----- hdl/ste_ctrl.sv -----
// Controller state machine for the smoothed target encoder.
// Uses ste_pkg for the command and status structs.
`default_nettype none
module ste_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              row_valid,
  output logic                   row_ready,
  input  wire logic              out_free,
  input  wire ste_pkg::ste_stat_t stat,
  output ste_pkg::ste_cmd_t      cmd
);
  import ste_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_ACC    = 4'd1;
  localparam logic [3:0] S_ENC    = 4'd2;
  localparam logic [3:0] S_MEAN   = 4'd3;
  localparam logic [3:0] S_MWAIT  = 4'd4;
  localparam logic [3:0] S_PROD   = 4'd5;
  localparam logic [3:0] S_WRD    = 4'd6;
  localparam logic [3:0] S_WEVAL  = 4'd7;
  localparam logic [3:0] S_WSTART = 4'd8;
  localparam logic [3:0] S_WWAIT  = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;

  assign row_ready = (state == S_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (row_valid) begin
          cmd.take   = 1'b1;
          state_next = S_ACC;
        end
      end
      S_ACC: begin
        if (stat.cmd_enc) begin
          state_next = S_ENC;
        end else begin
          cmd.acc_wr = 1'b1;
          state_next = stat.last ? S_MEAN : S_IDLE;
        end
      end
      S_ENC: begin
        if (out_free) begin
          cmd.enc_take = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_MEAN: begin
        if (stat.rows_zero) begin
          cmd.mean_zero = 1'b1;
          state_next    = S_PROD;
        end else begin
          cmd.mean_start = 1'b1;
          state_next     = S_MWAIT;
        end
      end
      S_MWAIT: begin
        if (stat.div_done) begin
          cmd.mean_load = 1'b1;
          state_next    = S_PROD;
        end
      end
      S_PROD: begin
        cmd.prod   = 1'b1;
        state_next = S_WRD;
      end
      S_WRD: state_next = S_WEVAL;
      S_WEVAL: begin
        if (stat.walk_skip) begin
          cmd.val_wr_mean = 1'b1;
          state_next      = stat.walk_end ? S_IDLE : S_WRD;
        end else begin
          cmd.num_load = 1'b1;
          state_next   = S_WSTART;
        end
      end
      S_WSTART: begin
        cmd.div_start = 1'b1;
        state_next    = S_WWAIT;
      end
      S_WWAIT: begin
        if (stat.div_done) begin
          cmd.val_wr_div = 1'b1;
          state_next     = stat.walk_end ? S_IDLE : S_WRD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end
endmodule
`default_nettype wire

// ----- hdl/ste_dp.sv -----
// Datapath: category tables, totals, smoothing register and the shared divider.
// Uses ste_pkg and ste_div.
`default_nettype none
module ste_dp (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire ste_pkg::ste_cmd_t            cmd,
  output ste_pkg::ste_stat_t                stat,
  input  wire logic                         cfg_we,
  input  wire logic [ste_pkg::SMOOTH_W-1:0] cfg_data,
  input  wire logic                         row_command,
  input  wire logic signed [ste_pkg::CODE_W-1:0] row_code,
  input  wire logic signed [ste_pkg::VAL_W-1:0]  row_target,
  input  wire logic                         row_last,
  output logic signed [ste_pkg::VAL_W-1:0]  enc_value,
  output logic                              enc_last
);
  import ste_pkg::*;

  logic [SMOOTH_W-1:0] smoothing;

  logic                     lat_cmd;
  logic                     lat_valid;
  logic [IDX_W-1:0]         lat_idx;
  logic signed [VAL_W-1:0]  lat_target;
  logic                     lat_last;

  logic signed [SUM_W-1:0]  sum_mem [NUM_CAT];
  logic [ROWS_W-1:0]        cnt_mem [NUM_CAT];
  logic signed [VAL_W-1:0]  val_mem [NUM_CAT];
  logic [NUM_CAT-1:0]       vld;

  logic [IDX_W-1:0]         rd_addr;
  logic signed [SUM_W-1:0]  sum_q;
  logic [ROWS_W-1:0]        cnt_q;
  logic signed [VAL_W-1:0]  val_q;
  logic                     vld_q;
  logic signed [SUM_W-1:0]  sum_rd;
  logic [ROWS_W-1:0]        cnt_rd;

  logic signed [SUM_W-1:0]  total_sum;
  logic [ROWS_W-1:0]        total_rows;
  logic signed [VAL_W-1:0]  gmean;
  logic signed [PROD_W-1:0] sm_prod;
  logic [IDX_W-1:0]         k;

  logic [DIVN_W-1:0]        num_mag;
  logic                     num_neg;
  logic [DIVD_W-1:0]        den;
  logic                     mean_neg;

  logic                     div_start;
  logic [DIVN_W-1:0]        div_n;
  logic [DIVD_W-1:0]        div_d;
  logic                     div_done;
  logic [DIVN_W-1:0]        div_q;

  logic                     code_ok;
  logic [SUM_W-1:0]         tsum_mag;
  logic [SUM_W-1:0]         sum_mag;
  logic [DIVN_W-1:0]        ma;
  logic [DIVN_W-1:0]        mb;
  logic [PROD_W-1:0]        prod_mag;
  logic                     na;
  logic                     nb;
  logic [DIVN_W-1:0]        q_clamp;
  logic signed [VAL_W-1:0]  div_val;

  assign code_ok = !row_code[CODE_W-1] &&
                   ({1'b0, row_code[CODE_W-2:0]} < CODE_W'(NUM_CAT));

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      smoothing <= SMOOTH_W'(256);
    end else if (cfg_we) begin
      smoothing <= cfg_data;
    end
  end

  // latch the accepted beat
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      lat_cmd    <= row_command;
      lat_valid  <= code_ok;
      lat_idx    <= row_code[IDX_W-1:0];
      lat_target <= row_target;
      lat_last   <= row_last;
    end
  end

  // table reads: input code on accept, otherwise the walk counter
  assign rd_addr = cmd.take ? row_code[IDX_W-1:0] : k;

  always_ff @(posedge clk) begin
    sum_q <= sum_mem[rd_addr];
    cnt_q <= cnt_mem[rd_addr];
  end

  // hold the category value of the accepted beat until its result is loaded
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      val_q <= val_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld[rd_addr];
    end
  end

  assign sum_rd = vld_q ? sum_q : '0;
  assign cnt_rd = vld_q ? cnt_q : '0;

  // sum and count write back
  always_ff @(posedge clk) begin
    if (cmd.acc_wr && lat_valid && (total_rows < ROWS_W'(MAX_ROWS))) begin
      sum_mem[lat_idx] <= sum_rd + SUM_W'(lat_target);
      cnt_mem[lat_idx] <= cnt_rd + 1'b1;
    end
  end

  // valid bits: set on write, clear on last encode row
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (cmd.enc_take && lat_last) begin
      vld <= '0;
    end else if (cmd.acc_wr && lat_valid && (total_rows < ROWS_W'(MAX_ROWS))) begin
      vld[lat_idx] <= 1'b1;
    end
  end

  // totals and global mean
  always_ff @(posedge clk) begin
    if (rst) begin
      total_sum  <= '0;
      total_rows <= '0;
      gmean      <= '0;
    end else if (cmd.enc_take && lat_last) begin
      total_sum  <= '0;
      total_rows <= '0;
      gmean      <= '0;
    end else begin
      if (cmd.acc_wr && (total_rows < ROWS_W'(MAX_ROWS))) begin
        total_sum  <= total_sum + SUM_W'(lat_target);
        total_rows <= total_rows + 1'b1;
      end
      if (cmd.mean_zero) begin
        gmean <= '0;
      end else if (cmd.mean_load) begin
        gmean <= mean_neg ? -div_q[VAL_W-1:0] : div_q[VAL_W-1:0];
      end
    end
  end

  assign tsum_mag = total_sum[SUM_W-1] ? (~total_sum + 1'b1) : total_sum;

  always_ff @(posedge clk) begin
    if (cmd.mean_start) begin
      mean_neg <= total_sum[SUM_W-1];
    end
  end

  // smoothing * mean, held for the walk; rewind walk counter
  always_ff @(posedge clk) begin
    if (cmd.prod) begin
      sm_prod <= $signed({1'b0, smoothing}) * gmean;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k <= '0;
    end else if (cmd.prod) begin
      k <= '0;
    end else if (cmd.val_wr_mean || cmd.val_wr_div) begin
      k <= k + 1'b1;
    end
  end

  // signed numerator as sign and magnitude
  assign sum_mag  = sum_rd[SUM_W-1] ? (~sum_rd + 1'b1) : sum_rd;
  assign prod_mag = sm_prod[PROD_W-1] ? (~sm_prod + 1'b1) : sm_prod;
  assign na       = sum_rd[SUM_W-1];
  assign nb       = sm_prod[PROD_W-1];
  assign ma       = DIVN_W'(sum_mag) << 8;
  assign mb       = DIVN_W'(prod_mag);

  always_ff @(posedge clk) begin
    if (cmd.num_load) begin
      den <= DIVD_W'({cnt_rd, 8'b0}) + DIVD_W'(smoothing);
      if (na == nb) begin
        num_mag <= ma + mb;
        num_neg <= na;
      end else if (ma >= mb) begin
        num_mag <= ma - mb;
        num_neg <= na;
      end else begin
        num_mag <= mb - ma;
        num_neg <= nb;
      end
    end
  end

  // shared divider
  assign div_start = cmd.mean_start || cmd.div_start;
  assign div_n     = cmd.mean_start ? DIVN_W'(tsum_mag) : num_mag;
  assign div_d     = cmd.mean_start ? DIVD_W'(total_rows) : den;

  ste_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .done     (div_done),
    .quotient (div_q)
  );

  // clamp quotient to the signed result range
  always_comb begin
    if (num_neg) begin
      q_clamp = (div_q > DIVN_W'(64'h8000_0000)) ? DIVN_W'(64'h8000_0000) : div_q;
      div_val = -q_clamp[VAL_W-1:0];
    end else begin
      q_clamp = (div_q > DIVN_W'(64'h7FFF_FFFF)) ? DIVN_W'(64'h7FFF_FFFF) : div_q;
      div_val = q_clamp[VAL_W-1:0];
    end
  end

  // category value writes during the walk
  always_ff @(posedge clk) begin
    if (cmd.val_wr_mean) begin
      val_mem[k] <= gmean;
    end else if (cmd.val_wr_div) begin
      val_mem[k] <= div_val;
    end
  end

  assign enc_value = lat_valid ? val_q : gmean;
  assign enc_last  = lat_last;

  assign stat.cmd_enc   = lat_cmd;
  assign stat.last      = lat_last;
  assign stat.rows_zero = (total_rows == '0);
  assign stat.walk_skip = (cnt_rd == '0);
  assign stat.walk_end  = (k == IDX_W'(NUM_CAT - 1));
  assign stat.div_done  = div_done;
endmodule
`default_nettype wire

// ----- hdl/smoothed_target_encoder_top.sv -----
// Top level of the smoothed target encoder: controller, datapath, result register.
// Uses ste_pkg, ste_intf, ste_ctrl and ste_dp.
//
//   channel  dir  payload
//   row      in   command, category_code, target_value, last_row
//   result   out  encoded_value, last_out
//   cfg      in   smoothing (16 bits)
//
// An accumulate row runs a table read, then a write back. An encode row runs
// a table read, a decode and a result load, waiting before the load while the
// result register still holds an untaken beat. The accumulate row marked last
// then runs a finalize: a mean division and a walk over all categories, in
// which an empty category skips the shared divider and any other goes
// through it.
// Reset is synchronous; tables need no clearing pass. A stalled result beat
// holds in the output register while the next accumulate rows go on.
`default_nettype none
module smoothed_target_encoder_top (
  input  wire logic clk,
  input  wire logic rst,
  ste_row_if.sink   row,
  ste_res_if.source result,
  ste_cfg_if.sink   cfg
);
  import ste_pkg::*;

  ste_cmd_t               cmd;
  ste_stat_t              stat;
  logic                   out_free;
  logic signed [VAL_W-1:0] enc_value;
  logic                   enc_last;

  assign cfg.ready = 1'b1;
  assign out_free  = !result.valid || result.ready;

  ste_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .row_valid (row.valid),
    .row_ready (row.ready),
    .out_free  (out_free),
    .stat      (stat),
    .cmd       (cmd)
  );

  ste_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .cfg_we      (cfg.valid),
    .cfg_data    (cfg.data),
    .row_command (row.command),
    .row_code    (row.category_code),
    .row_target  (row.target_value),
    .row_last    (row.last_row),
    .enc_value   (enc_value),
    .enc_last    (enc_last)
  );

  // result register: load on encode, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (cmd.enc_take) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.enc_take) begin
      result.encoded_value <= enc_value;
      result.last_out      <= enc_last;
    end
  end
endmodule
`default_nettype wire
